>>> src/bffa_pkg.sv
`default_nettype none

package bffa_pkg;

  localparam int unsigned MAX_INODES_DEF = 4096;
  localparam int unsigned MAX_ZONES_DEF  = 65536;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned LIMIT_W     = 17;
  localparam int unsigned FIELD_REACH = 65536;
  // Positions are 16 bits wide, so no more than 2048 words are ever reached.
  localparam int unsigned WADDR_W     = IDX_W - BIT_W;
  localparam int unsigned REACH_WORDS = FIELD_REACH / WORD_BITS;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic MAP_INODE  = 1'b0;
  localparam logic MAP_ZONE   = 1'b1;

  // Only paddr bit 2 is decoded: it picks the inode or the zone count.
  localparam logic REG_INODE_COUNT = 1'b0;
  localparam logic REG_ZONE_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic             mode;
    logic             map_select;
    logic [IDX_W-1:0] bit_index;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  // Index of the lowest set bit; only meaningful when v is nonzero.
  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> src/bffa_ram.sv
`default_nettype none

module bffa_ram #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                          clk_i,
  input  wire bffa_pkg::mem_req_t            req_i,
  output logic [bffa_pkg::WORD_BITS-1:0]     rdata_o
);
  import bffa_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 in_range;

  assign in_range = ({1'b0, req_i.addr} < (WADDR_W + 1)'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (req_i.we && in_range) begin
      mem[AW'(req_i.addr)] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re && in_range) begin
      rdata_q <= mem[AW'(req_i.addr)];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/bffa_ctrl.sv
`default_nettype none

module bffa_ctrl #(
  parameter int unsigned CLEAR_WORDS = 2048
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire bffa_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output bffa_pkg::out_item_t                out_data_o,
  input  wire logic [bffa_pkg::LIMIT_W-1:0]  inode_limit_i,
  input  wire logic [bffa_pkg::LIMIT_W-1:0]  zone_limit_i,
  output bffa_pkg::mem_req_t                 ireq_o,
  output bffa_pkg::mem_req_t                 zreq_o,
  input  wire logic [bffa_pkg::WORD_BITS-1:0] irdata_i,
  input  wire logic [bffa_pkg::WORD_BITS-1:0] zrdata_i
);
  import bffa_pkg::*;

  localparam logic [WADDR_W-1:0] CLR_LAST = WADDR_W'(CLEAR_WORDS - 1);

  state_e               state_q, state_d;
  logic [WADDR_W-1:0]   clr_q, clr_d;
  logic [WADDR_W-1:0]   chk_q, chk_d;
  logic [LIMIT_W-1:0]   lim_q, lim_d;
  in_item_t             op_q, op_d;
  out_item_t            hold_q, hold_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  mem_req_t             req;
  logic                 req_all;
  logic                 req_sel;
  logic                 fin_vld;
  out_item_t            fin_item;
  logic                 slot_free;
  logic [LIMIT_W-1:0]   sel_lim;
  logic [WORD_BITS-1:0] rdata;
  logic [LIMIT_W-1:0]   lim_m1;
  logic [WADDR_W-1:0]   last_word;
  logic                 is_last;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     hit;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign rdata     = (op_q.map_select == MAP_ZONE) ? zrdata_i : irdata_i;
  assign sel_lim   = (in_data_i.map_select == MAP_ZONE) ? zone_limit_i : inode_limit_i;

  // The last word in use may be partly beyond the limit; those bits read as taken.
  assign lim_m1     = lim_q - LIMIT_W'(1);
  assign last_word  = lim_m1[IDX_W-1:BIT_W];
  assign is_last    = (chk_q == last_word);
  assign valid_mask = (!is_last || lim_q[BIT_W-1:0] == '0) ? '1
                    : ((WORD_BITS'(1) << lim_q[BIT_W-1:0]) - WORD_BITS'(1));
  assign free_bits  = ~rdata & valid_mask;
  assign hit        = first_one(free_bits);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    chk_d       = chk_q;
    lim_d       = lim_q;
    op_d        = op_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    req         = '0;
    req_all     = 1'b0;
    req_sel     = op_q.map_select;
    fin_vld     = 1'b0;
    fin_item    = '0;

    unique case (state_q)
      S_CLEAR: begin
        req.we  = 1'b1;
        req.addr = clr_q;
        req_all = 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + WADDR_W'(1);
        end
      end
      S_IDLE: begin
        req_sel = in_data_i.map_select;
        if (in_valid_i) begin
          op_d  = in_data_i;
          lim_d = sel_lim;
          if (in_data_i.mode == MODE_ALLOC) begin
            if (sel_lim == '0) begin
              fin_vld         = 1'b1;
              fin_item.status = STATUS_NO_FREE;
            end else begin
              req.re  = 1'b1;
              req.addr = '0;
              chk_d   = '0;
              state_d = S_SCAN;
            end
          end else begin
            if ({1'b0, in_data_i.bit_index} >= sel_lim) begin
              fin_vld         = 1'b1;
              fin_item.status = STATUS_RANGE;
            end else begin
              req.re   = 1'b1;
              req.addr = in_data_i.bit_index[IDX_W-1:BIT_W];
              state_d  = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          req.we            = 1'b1;
          req.addr          = chk_q;
          req.wdata         = rdata | (WORD_BITS'(1) << hit);
          fin_vld           = 1'b1;
          fin_item.status   = STATUS_OK;
          fin_item.position = {chk_q, hit};
        end else if (is_last) begin
          fin_vld         = 1'b1;
          fin_item.status = STATUS_NO_FREE;
        end else begin
          // Fetch the next word while this one is being examined.
          req.re   = 1'b1;
          req.addr = chk_q + WADDR_W'(1);
          chk_d    = chk_q + WADDR_W'(1);
        end
      end
      S_FREE: begin
        req.we          = 1'b1;
        req.addr        = op_q.bit_index[IDX_W-1:BIT_W];
        req.wdata       = rdata & ~(WORD_BITS'(1) << op_q.bit_index[BIT_W-1:0]);
        fin_vld         = 1'b1;
        fin_item.status = STATUS_OK;
      end
      S_HOLD: begin
        if (slot_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin_vld) begin
      if (slot_free) begin
        out_d       = fin_item;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        hold_d  = fin_item;
        state_d = S_HOLD;
      end
    end
  end

  always_comb begin
    ireq_o    = req;
    zreq_o    = req;
    ireq_o.we = req.we && (req_all || req_sel == MAP_INODE);
    ireq_o.re = req.re && (req_sel == MAP_INODE);
    zreq_o.we = req.we && (req_all || req_sel == MAP_ZONE);
    zreq_o.re = req.re && (req_sel == MAP_ZONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q  <= chk_d;
    lim_q  <= lim_d;
    op_q   <= op_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> src/bitmap_first_free_allocator.sv
// An allocate scans the bitmap from word 0 for the first free bit, reading 32-bit words
// one word per cycle through the bitmap RAM read port, up to 2048 words. A free reads
// its word and writes it back with the bit cleared; a range error or empty map answers
// at the accept edge unless a stalled result is held. A new beat is taken once the last
// result is in the output register, even if it waits. After reset a clearing pass zeroes
// both bitmaps over max(inode, zone) words, 2048 by default, while no beat is accepted.
`default_nettype none

module bitmap_first_free_allocator #(
  parameter int unsigned MAX_INODES = bffa_pkg::MAX_INODES_DEF,
  parameter int unsigned MAX_ZONES  = bffa_pkg::MAX_ZONES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire bffa_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output bffa_pkg::out_item_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bffa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bffa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bffa_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import bffa_pkg::*;

  localparam int unsigned IWORDS    = (MAX_INODES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ZWORDS    = (MAX_ZONES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned IDEPTH    = (IWORDS > REACH_WORDS) ? REACH_WORDS : IWORDS;
  localparam int unsigned ZDEPTH    = (ZWORDS > REACH_WORDS) ? REACH_WORDS : ZWORDS;
  localparam int unsigned CLR_WORDS = (IDEPTH > ZDEPTH) ? IDEPTH : ZDEPTH;
  localparam int unsigned ILIM      = (MAX_INODES > FIELD_REACH) ? FIELD_REACH : MAX_INODES;
  localparam int unsigned ZLIM      = (MAX_ZONES > FIELD_REACH) ? FIELD_REACH : MAX_ZONES;

  localparam int unsigned ICNT_W = 13;
  localparam int unsigned ZCNT_W = 17;

  logic [ICNT_W-1:0]    inode_count_q;
  logic [ZCNT_W-1:0]    zone_count_q;
  logic                 wr_en;
  logic [LIMIT_W-1:0]   inode_ext;
  logic [LIMIT_W-1:0]   zone_ext;
  logic [LIMIT_W-1:0]   inode_limit;
  logic [LIMIT_W-1:0]   zone_limit;
  mem_req_t             ireq;
  mem_req_t             zreq;
  logic [WORD_BITS-1:0] irdata;
  logic [WORD_BITS-1:0] zrdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_count_q <= ICNT_W'(4096);
      zone_count_q  <= ZCNT_W'(65536);
    end else if (wr_en) begin
      if (paddr[2] == REG_INODE_COUNT) begin
        inode_count_q <= pwdata[ICNT_W-1:0];
      end else begin
        zone_count_q <= pwdata[ZCNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ZONE_COUNT) ? PDATA_W'(zone_count_q)
                                               : PDATA_W'(inode_count_q);

  // Counts beyond the map size or the 16-bit index reach are cut down.
  assign inode_ext   = LIMIT_W'(inode_count_q);
  assign zone_ext    = LIMIT_W'(zone_count_q);
  assign inode_limit = (inode_ext > LIMIT_W'(ILIM)) ? LIMIT_W'(ILIM) : inode_ext;
  assign zone_limit  = (zone_ext > LIMIT_W'(ZLIM)) ? LIMIT_W'(ZLIM) : zone_ext;

  bffa_ram #(
    .DEPTH (IDEPTH)
  ) u_inode_ram (
    .clk_i   (clk_i),
    .req_i   (ireq),
    .rdata_o (irdata)
  );

  bffa_ram #(
    .DEPTH (ZDEPTH)
  ) u_zone_ram (
    .clk_i   (clk_i),
    .req_i   (zreq),
    .rdata_o (zrdata)
  );

  bffa_ctrl #(
    .CLEAR_WORDS (CLR_WORDS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .inode_limit_i (inode_limit),
    .zone_limit_i  (zone_limit),
    .ireq_o        (ireq),
    .zreq_o        (zreq),
    .irdata_i      (irdata),
    .zrdata_i      (zrdata)
  );

endmodule

`default_nettype wire
